### rtl/core/sfrt_pkg.sv
package sfrt_pkg;

  localparam int PID_W       = 13;
  localparam int SEQ_W       = 3;
  localparam int EXP_W       = 4;
  localparam int LATE_W      = 4;
  localparam int STREAM_W    = 3;
  localparam int MASK_W      = 8;
  localparam int CFG_W       = 13;
  localparam int THR_W       = 4;

  localparam int STREAMS_DEF     = 8;
  localparam int MAX_PACKETS_DEF = 8;

  localparam logic [THR_W-1:0] THR_RESET = 4'd5;

  typedef enum logic [0:0] {
    REG_BASE_PID       = 1'b0,
    REG_LOSS_THRESHOLD = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             present;
    logic [PID_W-1:0] pid;
    logic [SEQ_W-1:0] seq;
    logic [EXP_W-1:0] expected_count;
  } pkt_t;

  typedef struct packed {
    logic                frame_done;
    logic [STREAM_W-1:0] done_stream;
    logic                reorder_flag;
    logic [MASK_W-1:0]   lost_mask;
    logic                pid_error;
  } res_t;

endpackage

### rtl/core/stream_frame_reassembly_tracker.sv
// Stream frame reassembly tracker.
// Packet slots arrive on the pkt channel (pkt_valid, pkt_stall, pkt). Each accepted
// slot produces exactly one result transaction on the res channel (res_valid,
// res_stall, res) carrying the completion flag, updated stream, reorder flag, the
// mask of streams declared lost and a PID error flag.
// Per-stream state lives in a single-port-read, single-port-write memory. After a
// slot is accepted the block sweeps every stream once: it reads one entry per
// cycle and writes the updated entry back in the next cycle, applying the packet
// to its own stream and aging all other incomplete streams. When the sweep ends
// the result is loaded into the output register; pkt_stall stays high from
// acceptance until that load, so the next slot is taken only after it.
// If the receiver stalls, the result register holds its transaction and the
// block still accepts and sweeps the next slot, waiting only to load its result.
// Configuration writes on the cfg channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data) are always taken and must only be issued while the block is idle.
// Synchronous reset clears every stream, sets base_pid to 0 and loss_threshold
// to 5, and empties the result register.
module stream_frame_reassembly_tracker #(
  parameter int STREAMS     = sfrt_pkg::STREAMS_DEF,
  parameter int MAX_PACKETS = sfrt_pkg::MAX_PACKETS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pkt_valid,
  output logic                         pkt_stall,
  input  sfrt_pkg::pkt_t               pkt,
  output logic                         res_valid,
  input  logic                         res_stall,
  output sfrt_pkg::res_t               res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  sfrt_pkg::cfg_index_t         cfg_index,
  input  logic [sfrt_pkg::CFG_W-1:0]   cfg_data
);
  import sfrt_pkg::*;

  localparam int SW   = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int CW   = $clog2(MAX_PACKETS);
  localparam int EW   = CW + LATE_W + 2;
  localparam int CMPW = (CW + 1 > EXP_W) ? CW + 1 : EXP_W;
  localparam int SQW  = (CW > SEQ_W) ? CW : SEQ_W;
  localparam logic [CW-1:0] CNT_LAST = CW'(MAX_PACKETS - 1);

  state_t state, state_next;

  logic [PID_W-1:0]  base_pid;
  logic [THR_W-1:0]  loss_threshold;
  logic [THR_W-1:0]  thr;

  logic [EW-1:0]     mem [STREAMS];
  logic [EW-1:0]     rd_data;
  logic              rd_ok;
  logic              rd_act;
  logic [SW-1:0]     rd_addr;
  logic              rd_en;
  logic [STREAMS-1:0] valid_bits;
  logic [SW:0]       scnt;

  pkt_t              pkt_q;
  logic [PID_W-1:0]  idx_q;
  logic              tracked_q;
  logic              perr_q;
  logic              done_acc;
  logic              reorder_acc;
  logic [MASK_W-1:0] lost_acc;

  logic              accept;
  logic              load_res;
  logic [PID_W-1:0]  idx_full;
  logic              in_range;

  logic [EW-1:0]     cur;
  logic [CW-1:0]     cur_cnt;
  logic [LATE_W-1:0] cur_late;
  logic              cur_inc;
  logic              cur_ooo;
  logic              hit;
  logic              ooo_new;
  logic [LATE_W-1:0] late_inc;
  logic [EW-1:0]     new_entry;
  logic              done_now;
  logic              reorder_now;
  logic              lost_now;
  logic [PID_W-1:0]  rd_addr_ext;
  logic [MASK_W-1:0] lost_vec;

  assign cfg_ready = 1'b1;
  assign thr       = (loss_threshold == '0) ? THR_W'(1) : loss_threshold;
  assign idx_full  = pkt.pid - base_pid;
  assign in_range  = idx_full < PID_W'(STREAMS);

  always_comb begin
    state_next = state;
    pkt_stall  = (state != ST_IDLE);
    accept     = pkt_valid && (state == ST_IDLE);
    rd_en      = (state == ST_RUN) && (scnt < (SW + 1)'(STREAMS));
    load_res   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (scnt == (SW + 1)'(STREAMS)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid || !res_stall) begin
          load_res   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cur         = rd_ok ? rd_data : '0;
    cur_cnt     = cur[EW-1 -: CW];
    cur_late    = cur[LATE_W+1:2];
    cur_inc     = cur[1];
    cur_ooo     = cur[0];
    rd_addr_ext = PID_W'(rd_addr);
    hit         = tracked_q && (rd_addr_ext == idx_q);
    ooo_new     = cur_ooo || (SQW'(pkt_q.seq) != SQW'(cur_cnt));
    late_inc    = cur_late + LATE_W'(1);
    new_entry   = cur;
    done_now    = 1'b0;
    reorder_now = 1'b0;
    lost_now    = 1'b0;
    if (hit) begin
      if (CMPW'(cur_cnt) + CMPW'(1) == CMPW'(pkt_q.expected_count)) begin
        done_now    = 1'b1;
        reorder_now = ooo_new;
        new_entry   = '0;
      end else begin
        new_entry = {((cur_cnt == CNT_LAST) ? '0 : cur_cnt + CW'(1)),
                     {LATE_W{1'b0}}, 1'b1, ooo_new};
      end
    end else if (cur_inc) begin
      if (late_inc >= thr) begin
        lost_now  = 1'b1;
        new_entry = '0;
      end else begin
        new_entry = {cur_cnt, late_inc, cur_inc, cur_ooo};
      end
    end
    lost_vec = MASK_W'(lost_now && (rd_addr_ext < PID_W'(MASK_W))) << rd_addr_ext[2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[scnt[SW-1:0]];
    end
    if (rd_act) begin
      mem[rd_addr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= scnt[SW-1:0];
    rd_ok   <= valid_bits[scnt[SW-1:0]];
    if (accept) begin
      pkt_q     <= pkt;
      idx_q     <= idx_full;
      tracked_q <= pkt.present && in_range;
      perr_q    <= pkt.present && !in_range;
    end
    if (rst) begin
      rd_act         <= 1'b0;
      scnt           <= '0;
      valid_bits     <= '0;
      base_pid       <= '0;
      loss_threshold <= THR_RESET;
      done_acc       <= 1'b0;
      reorder_acc    <= 1'b0;
      lost_acc       <= '0;
    end else begin
      rd_act <= rd_en;
      if (accept) begin
        scnt        <= '0;
        done_acc    <= 1'b0;
        reorder_acc <= 1'b0;
        lost_acc    <= '0;
      end else if (state == ST_RUN) begin
        scnt <= scnt + (SW + 1)'(1);
      end
      if (rd_act) begin
        valid_bits[rd_addr] <= 1'b1;
        done_acc            <= done_acc || done_now;
        reorder_acc         <= reorder_acc || reorder_now;
        lost_acc            <= lost_acc | lost_vec;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_PID:       base_pid <= cfg_data[PID_W-1:0];
          REG_LOSS_THRESHOLD: loss_threshold <= cfg_data[THR_W-1:0];
          default:            base_pid <= base_pid;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
    if (load_res) begin
      res.frame_done   <= done_acc;
      res.done_stream  <= tracked_q ? idx_q[STREAM_W-1:0] : '0;
      res.reorder_flag <= reorder_acc;
      res.lost_mask    <= lost_acc;
      res.pid_error    <= perr_q;
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && !pkt_stall |=> pkt_stall)
    else $error("A second transaction could be accepted during a sweep.");

  a_done_not_err: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_done |-> !res.pid_error)
    else $error("Completed frame reported together with a PID error.");

  a_reorder_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.reorder_flag |-> res.frame_done)
    else $error("Reorder flag set without a completed frame.");

  a_res_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_DONE)
    else $error("Result loaded outside the end of a sweep.");

  a_write_in_run: assert property (@(posedge clk) disable iff (rst)
    rd_act |-> state == ST_RUN)
    else $error("Memory write back outside a sweep.");

endmodule
